/* hdl/bmd_pkg.sv */
// shared constants and types for the binary message deframer
package bmd_pkg;

  localparam int unsigned HEADER_BYTES  = 23;
  localparam int unsigned CAPTURE_LIMIT = 1024;
  localparam int unsigned COUNT_MAX     = 2047;

  // capture count saturates at CAPTURE_LIMIT (1024), below the 11-bit maximum
  localparam int unsigned CAPTURE_CAP =
      (CAPTURE_LIMIT > COUNT_MAX) ? COUNT_MAX : CAPTURE_LIMIT;

  localparam int unsigned HDR_CNT_W = 5;
  localparam int unsigned CAPT_W    = 11;
  localparam int unsigned LEN_W     = 32;

  // header byte positions
  localparam logic [HDR_CNT_W-1:0] POS_TYPE = 5'd16;
  localparam logic [HDR_CNT_W-1:0] POS_TTL  = 5'd17;
  localparam logic [HDR_CNT_W-1:0] POS_HOPS = 5'd18;
  localparam logic [HDR_CNT_W-1:0] POS_LEN0 = 5'd19;
  localparam logic [HDR_CNT_W-1:0] POS_LEN1 = 5'd20;
  localparam logic [HDR_CNT_W-1:0] POS_LEN2 = 5'd21;
  localparam logic [HDR_CNT_W-1:0] POS_LEN3 = 5'd22;
  localparam logic [HDR_CNT_W-1:0] POS_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  localparam logic [CAPT_W-1:0] CAPT_CAP_V = CAPT_W'(CAPTURE_CAP);

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_TUSER_W = 3;

  // result item as carried in the output register
  typedef struct packed {
    logic              from_orig;
    logic              byte_valid;
    logic [7:0]        payload_byte;
    logic              message_end;
    logic [7:0]        pkt_type;
    logic [7:0]        ttl;
    logic [7:0]        hops;
    logic [LEN_W-1:0]  length;
    logic [CAPT_W-1:0] captured;
  } result_t;

endpackage

/* hdl/binary_message_deframer_core.sv */
// two-direction binary message header deframer, top level
// output: a byte accepted at a clock edge that yields a result registers it in
//   the output register at that edge, so it shows in the next cycle
// throughput: one byte per cycle unless the output stalls; the per-direction
//   framing update is a counter step and 32-bit compares on the remaining count
// reset: rst_ni clears the framing state of both directions and the output
//   valid flag at once; no clearing pass is needed
module binary_message_deframer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [bmd_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  logic [bmd_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,  // [0] from_originator
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] payload_byte, [15:8] out_type, [23:16] out_ttl, [31:24] out_hops,
  // [63:32] out_length, [74:64] out_captured, [79:75] zero
  output logic [bmd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // [0] result_from_originator, [1] byte_valid, [2] message_end
  output logic [bmd_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o
);
  import bmd_pkg::*;

  // per-direction framing state, index 1 is the originator side
  logic [HDR_CNT_W-1:0] hdr_cnt_q   [2];
  logic [7:0]           type_q      [2];
  logic [7:0]           ttl_q       [2];
  logic [7:0]           hops_q      [2];
  logic [LEN_W-1:0]     len_q       [2];
  logic [LEN_W-1:0]     remain_q    [2];
  logic [CAPT_W-1:0]    capt_q      [2];

  // next values for the direction of the current request
  logic [HDR_CNT_W-1:0] hdr_cnt_d;
  logic [7:0]           type_d;
  logic [7:0]           ttl_d;
  logic [7:0]           hops_d;
  logic [LEN_W-1:0]     len_d;
  logic [LEN_W-1:0]     remain_d;
  logic [CAPT_W-1:0]    capt_d;

  logic       dir;
  logic [7:0] din;
  logic       in_accept;
  logic       out_take;
  logic       byte_vld;
  logic       msg_end;
  logic       has_result;

  result_t    res_d;
  result_t    res_q;
  logic       out_valid_q;

  assign dir = s_axis_tuser_i[0];
  assign din = s_axis_tdata_i[7:0];

  // the output register takes a new result whenever it is empty or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take        = out_valid_q && m_axis_tready_i;

  // framing update for one byte
  always_comb begin
    hdr_cnt_d = hdr_cnt_q[dir];
    type_d    = type_q[dir];
    ttl_d     = ttl_q[dir];
    hops_d    = hops_q[dir];
    len_d     = len_q[dir];
    remain_d  = remain_q[dir];
    capt_d    = capt_q[dir];
    byte_vld  = 1'b0;
    msg_end   = 1'b0;

    if (remain_q[dir] == '0) begin
      // header phase
      unique case (hdr_cnt_q[dir])
        POS_TYPE: type_d = din;
        POS_TTL:  ttl_d  = din;
        POS_HOPS: hops_d = din;
        POS_LEN0: len_d  = {24'd0, din};
        POS_LEN1: len_d  = len_q[dir] | {16'd0, din, 8'd0};
        POS_LEN2: len_d  = len_q[dir] | {8'd0, din, 16'd0};
        POS_LEN3: len_d  = len_q[dir] | {din, 24'd0};
        default: ;
      endcase
      if (hdr_cnt_q[dir] >= POS_LAST) begin
        // header complete: arm payload count, restart capture count
        hdr_cnt_d = '0;
        capt_d    = '0;
        remain_d  = len_d;
        msg_end   = (len_d == '0);
      end else begin
        hdr_cnt_d = hdr_cnt_q[dir] + HDR_CNT_W'(1);
      end
    end else begin
      // payload phase
      if (capt_q[dir] < CAPT_CAP_V) begin
        capt_d   = capt_q[dir] + CAPT_W'(1);
        byte_vld = 1'b1;
      end
      remain_d = remain_q[dir] - LEN_W'(1);
      msg_end  = (remain_q[dir] == LEN_W'(1));
    end

    has_result = byte_vld || msg_end;

    // unused fields read as zero
    res_d.from_orig    = dir;
    res_d.byte_valid   = byte_vld;
    res_d.payload_byte = byte_vld ? din : 8'd0;
    res_d.message_end  = msg_end;
    res_d.pkt_type     = msg_end ? type_d : 8'd0;
    res_d.ttl          = msg_end ? ttl_d  : 8'd0;
    res_d.hops         = msg_end ? hops_d : 8'd0;
    res_d.length       = msg_end ? len_d  : '0;
    res_d.captured     = msg_end ? capt_d : '0;
  end

  // framing state registers, only the addressed direction moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        hdr_cnt_q[i] <= '0;
        type_q[i]    <= '0;
        ttl_q[i]     <= '0;
        hops_q[i]    <= '0;
        len_q[i]     <= '0;
        remain_q[i]  <= '0;
        capt_q[i]    <= '0;
      end
    end else if (in_accept) begin
      hdr_cnt_q[dir] <= hdr_cnt_d;
      type_q[dir]    <= type_d;
      ttl_q[dir]     <= ttl_d;
      hops_q[dir]    <= hops_d;
      len_q[dir]     <= len_d;
      remain_q[dir]  <= remain_d;
      capt_q[dir]    <= capt_d;
    end
  end

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept && has_result) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, res_q.captured, res_q.length, res_q.hops,
                            res_q.ttl, res_q.pkt_type, res_q.payload_byte};
  assign m_axis_tuser_o  = {res_q.message_end, res_q.byte_valid, res_q.from_orig};

endmodule

/* hdl/bmd_checker.sv */
// port-level checker for the deframer, bound to the top level
module bmd_port_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [bmd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic [bmd_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o
);
  import bmd_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // every result carries a byte or an end
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[1] || m_axis_tuser_o[2]))
    else $error("empty result");

  // header fields only on message end
  a_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[2] |-> (m_axis_tdata_o[79:8] == '0))
    else $error("header fields without message end");

  // captured count never exceeds the cap
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[74:64] <= CAPT_CAP_V))
    else $error("captured count above cap");

  // a full output register that is not drained blocks the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while result stalled");

endmodule

bind binary_message_deframer_core bmd_port_checker u_bmd_checker (.*);
